// ===== hw/rtl/vtct_pkg.sv =====
// Shared types and command codes for the versioned task claim table.
package vtct_pkg;

    // Command codes
    localparam logic [3:0] CMD_ACTIVATE     = 4'd0;
    localparam logic [3:0] CMD_READ         = 4'd1;
    localparam logic [3:0] CMD_CLAIM        = 4'd2;
    localparam logic [3:0] CMD_COMMIT       = 4'd3;
    localparam logic [3:0] CMD_RELEASE      = 4'd4;
    localparam logic [3:0] CMD_RESET        = 4'd5;
    localparam logic [3:0] CMD_CMP_XCHG     = 4'd6;
    localparam logic [3:0] CMD_SET_PREVIOUS = 4'd7;
    localparam logic [3:0] CMD_SET_RECOVERY = 4'd8;

    // Ownership word state codes
    localparam logic [1:0] OWN_EMPTY     = 2'd0;
    localparam logic [1:0] OWN_PENDING   = 2'd1;
    localparam logic [1:0] OWN_COMMITTED = 2'd2;

    localparam logic [29:0] CLIENT_LIMIT_RESET = 30'h3FFF_FFFF;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // One table entry as kept in memory
    typedef struct packed {
        logic [63:0] word;
        logic [31:0] prior;
        logic        recovery;
        logic [31:0] round;
    } entry_t;

    // Captured command
    typedef struct packed {
        logic [3:0]  command;
        logic [31:0] client_id;
        logic [63:0] expected;
        logic [63:0] desired;
        logic        flag;
        logic [31:0] round;
    } req_t;

    // Write-back request from the execute logic
    typedef struct packed {
        logic   mem_we;
        logic   set_reg;
        entry_t entry;
    } upd_t;

    // Result transaction contents
    typedef struct packed {
        logic        success;
        logic [63:0] word;
        logic [1:0]  state;
        logic [29:0] trainer;
        logic [30:0] version;
        logic [31:0] prior;
        logic        recovery;
        logic [31:0] round;
    } rsp_t;

endpackage

// ===== hw/rtl/vtct_mem.sv =====
// Single-port-write, registered-read entry memory for the claim table.
module vtct_mem
    import vtct_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
)
(
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data
);

    entry_t mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/vtct_exec.sv =====
// Command evaluation: new entry contents and the post-command result view.
module vtct_exec
    import vtct_pkg::*;
(
    input  req_t        req,
    input  entry_t      cur,
    input  logic        in_range,
    input  logic        reg_bit,
    input  logic [29:0] client_limit,
    output upd_t        upd,
    output rsp_t        rsp
);

    logic        live;
    logic        trainer_ok;
    logic        owner_match;
    logic [30:0] ver_inc;
    logic        ok;
    logic        live_after;
    entry_t      after;

    assign live        = in_range & reg_bit;
    assign trainer_ok  = (req.client_id != 32'd0) && (req.client_id <= {2'b00, client_limit});
    assign owner_match = (cur.word[1:0] == OWN_PENDING) &&
                         ({2'b00, cur.word[31:2]} == req.client_id);
    assign ver_inc     = cur.word[62:32] + 31'd1;

    // Decide the write-back per command
    always_comb
    begin
        upd       = '0;
        upd.entry = cur;
        ok        = 1'b0;
        case (req.command)
            CMD_ACTIVATE:
            begin
                if (in_range)
                begin
                    ok = 1'b1;
                    if (!reg_bit)
                    begin
                        upd.mem_we         = 1'b1;
                        upd.set_reg        = 1'b1;
                        upd.entry.word     = '0;
                        upd.entry.prior    = '0;
                        upd.entry.recovery = 1'b0;
                        upd.entry.round    = req.round;
                    end
                end
            end
            CMD_READ:
            begin
                ok = live;
            end
            CMD_CLAIM:
            begin
                if (live && trainer_ok && cur.word[1:0] == OWN_EMPTY)
                begin
                    ok             = 1'b1;
                    upd.mem_we     = 1'b1;
                    upd.entry.word = {1'b0, ver_inc, req.client_id[29:0], OWN_PENDING};
                end
            end
            CMD_COMMIT:
            begin
                if (live && trainer_ok && owner_match)
                begin
                    ok             = 1'b1;
                    upd.mem_we     = 1'b1;
                    upd.entry.word = {1'b0, ver_inc, req.client_id[29:0], OWN_COMMITTED};
                end
            end
            CMD_RELEASE:
            begin
                if (live && trainer_ok && owner_match)
                begin
                    ok             = 1'b1;
                    upd.mem_we     = 1'b1;
                    upd.entry.word = {1'b0, ver_inc, 30'd0, OWN_EMPTY};
                end
            end
            CMD_RESET:
            begin
                if (live)
                begin
                    ok             = 1'b1;
                    upd.mem_we     = 1'b1;
                    upd.entry.word = {1'b0, ver_inc, 30'd0, OWN_EMPTY};
                end
            end
            CMD_CMP_XCHG:
            begin
                if (live && cur.word == req.expected)
                begin
                    ok             = 1'b1;
                    upd.mem_we     = 1'b1;
                    upd.entry.word = req.desired;
                end
            end
            CMD_SET_PREVIOUS:
            begin
                if (live)
                begin
                    ok              = 1'b1;
                    upd.mem_we      = 1'b1;
                    upd.entry.prior = req.client_id;
                end
            end
            CMD_SET_RECOVERY:
            begin
                if (live)
                begin
                    ok                 = 1'b1;
                    upd.mem_we         = 1'b1;
                    upd.entry.recovery = req.flag;
                end
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    // Build the post-command view
    assign live_after = in_range & (reg_bit | upd.set_reg);
    assign after      = upd.mem_we ? upd.entry : cur;

    always_comb
    begin
        rsp         = '0;
        rsp.success = ok;
        if (live_after)
        begin
            rsp.word     = after.word;
            rsp.state    = after.word[1:0];
            rsp.trainer  = after.word[31:2];
            rsp.version  = after.word[62:32];
            rsp.prior    = after.prior;
            rsp.recovery = after.recovery;
            rsp.round    = after.round;
        end
        else
        begin
            rsp.word = '1;
        end
    end

endmodule

// ===== hw/rtl/versioned_task_claim_table_unit.sv =====
// Top level of the versioned task claim table.
//
// Command channel (in_valid/in_ready) carries one command per transaction:
// activate, read, claim, commit, release, reset, compare-exchange,
// set-previous or set-recovery on one task slot. Result channel
// (out_valid/out_ready) returns one transaction per command with the
// success bit and the slot's post-command view.
// For each command, the accept cycle issues the entry memory read and the
// execute state then evaluates it and writes the entry back. The single
// read-modify-write on the entry memory means a new command is not accepted
// until the previous one has been evaluated and written back.
// A result waits in the output register while the next command is
// accepted; if the receiver still stalls when that command is evaluated,
// the block holds it in the execute cycle until the register frees.
// Reset clears the registered bits (one flip-flop per slot), the result
// valid and sets client_limit to its maximum; entry memory is not cleared,
// activate fills an entry before any use. The user must write client_limit
// via cfg_wr_en/cfg_wr_data only while idle; the block does not enforce it.
module versioned_task_claim_table_unit
    import vtct_pkg::*;
#(
    parameter int TASK_SLOTS = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [29:0]        cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [3:0]         command,
    input  logic [7:0]         task_index,
    input  logic [31:0]        client_id,
    input  logic signed [63:0] expected_word,
    input  logic signed [63:0] desired_word,
    input  logic               flag_value,
    input  logic [31:0]        round_number,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               success,
    output logic signed [63:0] word_value,
    output logic [1:0]         state_field,
    output logic [29:0]        trainer_field,
    output logic [30:0]        version_field,
    output logic [31:0]        previous_client,
    output logic               recovery_flag,
    output logic [31:0]        created_round_out
);

    localparam int DEPTH = (TASK_SLOTS < 256) ? TASK_SLOTS : 256;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    state_t           state_reg, state_next;
    logic [29:0]      client_limit_reg;
    logic [DEPTH-1:0] registered_reg, registered_next;
    req_t             req_reg;
    logic [7:0]       index_reg;
    logic             out_valid_reg, out_valid_next;
    rsp_t             rsp_reg;

    logic             accept;
    logic             exec_done;
    logic             in_range;
    logic [AW-1:0]    addr;
    logic             reg_bit;
    entry_t           cur_entry;
    upd_t             upd;
    rsp_t             rsp;

    assign accept   = in_valid & in_ready;
    assign addr     = index_reg[AW-1:0];
    assign in_range = {9'd0, index_reg} < 17'(TASK_SLOTS);
    assign reg_bit  = in_range ? registered_reg[addr] : 1'b0;

    // Sequence the read-modify-write
    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        exec_done      = 1'b0;
        out_valid_next = out_valid_reg & ~out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    exec_done      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Mark slots registered on first activate
    always_comb
    begin
        registered_next = registered_reg;
        if (exec_done && upd.set_reg)
        begin
            registered_next[addr] = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            client_limit_reg <= CLIENT_LIMIT_RESET;
            registered_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            registered_reg <= registered_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
            begin
                client_limit_reg <= cfg_wr_data;
            end
        end
    end

    // Capture the command transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            index_reg        <= task_index;
            req_reg.command   <= command;
            req_reg.client_id <= client_id;
            req_reg.expected  <= expected_word;
            req_reg.desired   <= desired_word;
            req_reg.flag      <= flag_value;
            req_reg.round     <= round_number;
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (exec_done)
        begin
            rsp_reg <= rsp;
        end
    end

    vtct_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (task_index[AW-1:0]),
        .rd_data (cur_entry),
        .wr_en   (exec_done & upd.mem_we),
        .wr_addr (addr),
        .wr_data (upd.entry)
    );

    vtct_exec u_exec (
        .req          (req_reg),
        .cur          (cur_entry),
        .in_range     (in_range),
        .reg_bit      (reg_bit),
        .client_limit (client_limit_reg),
        .upd          (upd),
        .rsp          (rsp)
    );

    assign out_valid         = out_valid_reg;
    assign success           = rsp_reg.success;
    assign word_value        = rsp_reg.word;
    assign state_field       = rsp_reg.state;
    assign trainer_field     = rsp_reg.trainer;
    assign version_field     = rsp_reg.version;
    assign previous_client   = rsp_reg.prior;
    assign recovery_flag     = rsp_reg.recovery;
    assign created_round_out = rsp_reg.round;

endmodule

// ===== hw/rtl/vtct_checker.sv =====
// Port-level assertions for the claim table and their bind to the top level.
module vtct_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic               success,
    input logic signed [63:0] word_value,
    input logic [1:0]         state_field,
    input logic [29:0]        trainer_field,
    input logic [30:0]        version_field
);

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(word_value) && $stable(success))
        else $error("stalled result changed or dropped");

    // Drop ready for the execute cycle after an accepted command
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("command accepted while another executes");

    // A new result appears only out of an execute cycle
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result without an executed command");

    // Decoded fields follow the word on a registered slot
    a_fields_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (word_value != -64'sd1) |->
            (state_field == word_value[1:0]) && (trainer_field == word_value[31:2]) &&
            (version_field == word_value[62:32]))
        else $error("decoded fields differ from word");

endmodule

bind versioned_task_claim_table_unit vtct_checker u_vtct_checker (.*);
